[hw/rtl/modbus_tcp_response_parser_macros.svh]
// Assertion macros shared by the response parser modules.
`ifndef MODBUS_TCP_RESPONSE_PARSER_MACROS_SVH
`define MODBUS_TCP_RESPONSE_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MTRP_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("mtrp assertion failed");

// Next-cycle implication, disabled during reset.
`define MTRP_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("mtrp assertion failed");

`endif

[hw/rtl/mtrp_pkg.sv]
// Types and constants for the Modbus TCP response parser.
`default_nettype none

package mtrp_pkg;

    localparam int DEFAULT_MAX_FRAME_BYTES = 260;
    localparam int HEADER_BYTES            = 9;
    localparam int EXC_FLAG_BIT            = 7;
    localparam int QUEUE_DEPTH             = 4;

    localparam logic OP_START = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    localparam logic [7:0] FN_READ_COILS    = 8'h01;
    localparam logic [7:0] FN_READ_DISCRETE = 8'h02;
    localparam logic [7:0] FN_READ_HOLDING  = 8'h03;
    localparam logic [7:0] FN_READ_INPUT    = 8'h04;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_TRANS    = 3'd2,
        ST_EXCEPT   = 3'd3,
        ST_FUNCTION = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        KIND_REG    = 2'd0,
        KIND_BIT    = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    // Work handed from the classifier to the result sequencer.
    typedef struct packed {
        logic        do_reg;
        logic        do_bits;
        logic [15:0] data;
        logic        do_status;
        status_t     status;
        logic [7:0]  exc;
    } job_t;

endpackage

`default_nettype wire

[hw/rtl/mtrp_if.sv]
// Valid/ready channel interfaces for response items and results.
`default_nettype none

interface mtrp_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [15:0] expected_transaction;
    logic [7:0]  expected_function;
    logic [7:0]  data_byte;
    logic        frame_end;

    modport source (output valid, operation, expected_transaction, expected_function,
                    data_byte, frame_end, input ready);
    modport sink   (input valid, operation, expected_transaction, expected_function,
                    data_byte, frame_end, output ready);
endinterface

interface mtrp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] value;
    logic [2:0]  status;
    logic [7:0]  exception_code;
    logic        last;

    modport source (output valid, kind, value, status, exception_code, last,
                    input ready);
    modport sink   (input valid, kind, value, status, exception_code, last,
                    output ready);
endinterface

`default_nettype wire

[hw/rtl/mtrp_front.sv]
// Byte classifier: tracks frame position and header checks, emits jobs.
`default_nettype none

`include "modbus_tcp_response_parser_macros.svh"

module mtrp_front #(
    parameter int MAX_FRAME_BYTES = mtrp_pkg::DEFAULT_MAX_FRAME_BYTES
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    mtrp_in_if.sink            item,
    output mtrp_pkg::job_t     job,
    output logic               push,
    input  wire logic          full
);
    import mtrp_pkg::*;

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CMP_W = (POS_W > 8) ? POS_W : 8;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      want_trans_reg, want_trans_next;
    logic [7:0]       want_fn_reg, want_fn_next;
    logic [7:0]       held_reg, held_next;
    logic [7:0]       got_fn_reg, got_fn_next;
    logic [7:0]       count_reg, count_next;
    status_t          verdict_reg, verdict_next;
    logic [7:0]       exc_reg, exc_next;

    logic             accept;
    logic             advance;
    logic [CMP_W-1:0] offset;
    logic             is_reg_fn;
    logic             is_bit_fn;
    status_t          final_status;

    assign item.ready = !full;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        want_trans_next = want_trans_reg;
        want_fn_next    = want_fn_reg;
        pos_next        = pos_reg;
        held_next       = held_reg;
        got_fn_next     = got_fn_reg;
        count_next      = count_reg;
        verdict_next    = verdict_reg;
        exc_next        = exc_reg;
        job             = '0;
        push            = 1'b0;
        final_status    = ST_OK;

        advance   = (pos_reg != POS_W'(MAX_FRAME_BYTES));
        offset    = CMP_W'(pos_reg) - CMP_W'(HEADER_BYTES);
        is_reg_fn = (got_fn_reg == FN_READ_HOLDING) || (got_fn_reg == FN_READ_INPUT);
        is_bit_fn = (got_fn_reg == FN_READ_COILS) || (got_fn_reg == FN_READ_DISCRETE);

        if (accept)
        begin
            if (item.operation == OP_START)
            begin
                want_trans_next = item.expected_transaction;
                want_fn_next    = item.expected_function;
                pos_next        = '0;
                held_next       = '0;
                got_fn_next     = '0;
                count_next      = '0;
                verdict_next    = ST_OK;
                exc_next        = '0;
            end
            else
            begin
                if (advance)
                begin
                    pos_next = pos_reg + POS_W'(1);
                    if (pos_reg == POS_W'(0))
                    begin
                        held_next = item.data_byte;
                    end
                    else if (pos_reg == POS_W'(1))
                    begin
                        if ({held_reg, item.data_byte} != want_trans_reg)
                            verdict_next = ST_TRANS;
                    end
                    else if (pos_reg == POS_W'(7))
                    begin
                        got_fn_next = item.data_byte;
                    end
                    else if (pos_reg == POS_W'(8))
                    begin
                        count_next = item.data_byte;
                        if (verdict_reg == ST_OK)
                        begin
                            if (got_fn_reg[EXC_FLAG_BIT])
                            begin
                                verdict_next = ST_EXCEPT;
                                exc_next     = item.data_byte;
                            end
                            else if (got_fn_reg != want_fn_reg)
                            begin
                                verdict_next = ST_FUNCTION;
                            end
                        end
                    end
                    else if (pos_reg >= POS_W'(HEADER_BYTES) && verdict_reg == ST_OK)
                    begin
                        if (is_reg_fn)
                        begin
                            if (!offset[0])
                                held_next = item.data_byte;
                            else if (offset < CMP_W'({count_reg[7:1], 1'b0}))
                            begin
                                job.do_reg = 1'b1;
                                job.data   = {held_reg, item.data_byte};
                            end
                        end
                        else if (is_bit_fn)
                        begin
                            if (offset < CMP_W'(count_reg))
                            begin
                                job.do_bits = 1'b1;
                                job.data    = {8'h00, item.data_byte};
                            end
                        end
                    end
                end

                if (item.frame_end)
                begin
                    if (pos_next < POS_W'(HEADER_BYTES))
                        final_status = ST_SHORT;
                    else
                        final_status = verdict_next;
                    job.do_status = 1'b1;
                    job.status    = final_status;
                    job.exc       = (final_status == ST_EXCEPT) ? exc_next : 8'h00;
                    // Close the frame; expectations stay.
                    pos_next      = '0;
                    held_next     = '0;
                    got_fn_next   = '0;
                    count_next    = '0;
                    verdict_next  = ST_OK;
                    exc_next      = '0;
                end
                push = job.do_reg || job.do_bits || job.do_status;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            want_trans_reg <= '0;
            want_fn_reg    <= '0;
            held_reg       <= '0;
            got_fn_reg     <= '0;
            count_reg      <= '0;
            verdict_reg    <= ST_OK;
            exc_reg        <= '0;
        end
        else
        begin
            pos_reg        <= pos_next;
            want_trans_reg <= want_trans_next;
            want_fn_reg    <= want_fn_next;
            held_reg       <= held_next;
            got_fn_reg     <= got_fn_next;
            count_reg      <= count_next;
            verdict_reg    <= verdict_next;
            exc_reg        <= exc_next;
        end
    end

    `MTRP_ASSERT_NOW(a_pos_bounded, clk, rst_n, 1'b1, pos_reg <= POS_W'(MAX_FRAME_BYTES))
    `MTRP_ASSERT_NEXT(a_start_clears, clk, rst_n, accept && item.operation == OP_START,
        pos_reg == '0)
    `MTRP_ASSERT_NOW(a_fn_after_header, clk, rst_n, got_fn_reg != 8'h00,
        pos_reg >= POS_W'(8))

endmodule

`default_nettype wire

[hw/rtl/mtrp_queue.sv]
// Short job queue between the classifier and the result sequencer.
`default_nettype none

module mtrp_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire mtrp_pkg::job_t  push_job,
    output logic                 full,
    input  wire logic            pop,
    output mtrp_pkg::job_t       head,
    output logic                 empty
);
    import mtrp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

[hw/rtl/mtrp_back.sv]
// Result sequencer: unpacks one job into results, one per cycle while the receiver is ready.
`default_nettype none

`include "modbus_tcp_response_parser_macros.svh"

module mtrp_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mtrp_pkg::job_t  head,
    input  wire logic            empty,
    output logic                 pop,
    mtrp_out_if.source           result
);
    import mtrp_pkg::*;

    logic        job_reg_do_reg,  job_reg_do_reg_next;
    logic        job_bits_reg,    job_bits_next;
    logic        job_status_reg,  job_status_next;
    logic [15:0] job_data_reg,    job_data_next;
    status_t     job_st_reg,      job_st_next;
    logic [7:0]  job_exc_reg,     job_exc_next;
    logic [2:0]  bit_idx_reg,     bit_idx_next;

    logic        out_valid_reg,   out_valid_next;
    kind_t       out_kind_reg,    out_kind_next;
    logic [15:0] out_value_reg,   out_value_next;
    status_t     out_status_reg,  out_status_next;
    logic [7:0]  out_exc_reg,     out_exc_next;
    logic        out_last_reg,    out_last_next;

    logic        out_free;
    logic        has_work;
    logic        emit;
    logic        rem_reg, rem_bits, rem_status;

    assign out_free = !out_valid_reg || result.ready;
    assign has_work = job_reg_do_reg || job_bits_reg || job_status_reg;
    assign emit     = has_work && out_free;

    always_comb
    begin
        out_valid_next  = out_valid_reg && !result.ready;
        out_kind_next   = out_kind_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_exc_next    = out_exc_reg;
        out_last_next   = out_last_reg;
        rem_reg         = job_reg_do_reg;
        rem_bits        = job_bits_reg;
        rem_status      = job_status_reg;
        bit_idx_next    = bit_idx_reg;

        if (emit)
        begin
            out_valid_next = 1'b1;
            if (job_reg_do_reg)
            begin
                out_kind_next   = KIND_REG;
                out_value_next  = job_data_reg;
                out_status_next = ST_OK;
                out_exc_next    = 8'h00;
                out_last_next   = 1'b0;
                rem_reg         = 1'b0;
            end
            else if (job_bits_reg)
            begin
                out_kind_next   = KIND_BIT;
                out_value_next  = {15'h0000, job_data_reg[bit_idx_reg]};
                out_status_next = ST_OK;
                out_exc_next    = 8'h00;
                out_last_next   = 1'b0;
                bit_idx_next    = bit_idx_reg + 3'd1;
                rem_bits        = (bit_idx_reg != 3'd7);
            end
            else
            begin
                out_kind_next   = KIND_STATUS;
                out_value_next  = 16'h0000;
                out_status_next = job_st_reg;
                out_exc_next    = job_exc_reg;
                out_last_next   = 1'b1;
                rem_status      = 1'b0;
            end
        end

        // Load the next job as soon as the current one runs out.
        pop = !empty && !(rem_reg || rem_bits || rem_status);

        job_reg_do_reg_next = rem_reg;
        job_bits_next       = rem_bits;
        job_status_next     = rem_status;
        job_data_next       = job_data_reg;
        job_st_next         = job_st_reg;
        job_exc_next        = job_exc_reg;
        if (pop)
        begin
            job_reg_do_reg_next = head.do_reg;
            job_bits_next       = head.do_bits;
            job_status_next     = head.do_status;
            job_data_next       = head.data;
            job_st_next         = head.status;
            job_exc_next        = head.exc;
            bit_idx_next        = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_reg_do_reg <= 1'b0;
            job_bits_reg   <= 1'b0;
            job_status_reg <= 1'b0;
            bit_idx_reg    <= 3'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            job_reg_do_reg <= job_reg_do_reg_next;
            job_bits_reg   <= job_bits_next;
            job_status_reg <= job_status_next;
            bit_idx_reg    <= bit_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_data_reg   <= job_data_next;
        job_st_reg     <= job_st_next;
        job_exc_reg    <= job_exc_next;
        out_kind_reg   <= out_kind_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_exc_reg    <= out_exc_next;
        out_last_reg   <= out_last_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.kind           = out_kind_reg;
    assign result.value          = out_value_reg;
    assign result.status         = out_status_reg;
    assign result.exception_code = out_exc_reg;
    assign result.last           = out_last_reg;

    `MTRP_ASSERT_NOW(a_status_is_last, clk, rst_n,
        out_valid_reg && out_kind_reg == KIND_STATUS, out_last_reg)
    `MTRP_ASSERT_NOW(a_bit_idx_in_bits, clk, rst_n, bit_idx_reg != 3'd0, job_bits_reg)
    `MTRP_ASSERT_NOW(a_no_pop_busy, clk, rst_n,
        (job_reg_do_reg || job_bits_reg || job_status_reg) && !emit, !pop)

endmodule

`default_nettype wire

[hw/rtl/modbus_tcp_response_parser.sv]
// Modbus TCP response parser, top level.
// Takes one start or response byte per transaction and returns register values (function
// codes 3/4), single bit values (1/2) and one closing status per frame. A byte is taken
// every cycle while the four-entry job queue has room; the result side gives one result
// per cycle from its output register while the receiver is ready, so a register pair gives
// one result, a coil byte eight results and a frame end one more. Sustained rate is set by
// that output stage; a coil byte that also ends the frame yields nine results.
`default_nettype none

module modbus_tcp_response_parser #(
    parameter int MAX_FRAME_BYTES = mtrp_pkg::DEFAULT_MAX_FRAME_BYTES
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    mtrp_in_if.sink    item,
    mtrp_out_if.source result
);
    import mtrp_pkg::*;

    job_t front_job;
    job_t head_job;
    logic push;
    logic full;
    logic pop;
    logic empty;

    mtrp_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .job   (front_job),
        .push  (push),
        .full  (full)
    );

    mtrp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (front_job),
        .full     (full),
        .pop      (pop),
        .head     (head_job),
        .empty    (empty)
    );

    mtrp_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head_job),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

endmodule

`default_nettype wire

[test/tb.sv]
// Self-checking testbench for the Modbus TCP response parser.
`timescale 1ns / 100ps

module tb;
    import mtrp_pkg::*;

    localparam int FRAME_LIMIT     = DEFAULT_MAX_FRAME_BYTES;
    localparam int RANDOM_ITEMS    = 140;
    localparam int HOLD_CYCLES     = 200;
    localparam int HOLD_AFTER      = 20;
    localparam int DRAIN_CYCLES    = 30;
    localparam int WATCHDOG_CYCLES = 2000;

    typedef struct packed {
        logic        op;
        logic [15:0] trans;
        logic [7:0]  fn;
        logic [7:0]  data;
        logic        fe;
    } response_item_t;

    typedef struct {
        kind_t       kind;
        logic [15:0] value;
        status_t     status;
        logic [7:0]  exc;
        logic        last;
    } parser_result_t;

    logic clk = 1'b0;
    logic rst_n;

    mtrp_in_if  in_ch ();
    mtrp_out_if out_ch ();

    modbus_tcp_response_parser #(
        .MAX_FRAME_BYTES(FRAME_LIMIT)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (in_ch),
        .result(out_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    response_item_t response_items[$];
    parser_result_t due_results[$];

    int items_taken   = 0;
    int total_items   = 0;
    int frames_built  = 0;
    int results_seen  = 0;
    int statuses_seen = 0;
    int mismatches    = 0;

    // Parser state mirror
    logic [8:0]  frame_pos;
    logic [15:0] want_trans;
    logic [7:0]  want_fn;
    logic [7:0]  held;
    logic [7:0]  got_fn;
    logic [7:0]  byte_count;
    status_t     verdict;
    logic [7:0]  saved_exc;

    // Stimulus side copy of the latest expectations
    logic [15:0] gen_trans;
    logic [7:0]  gen_fn;

    function automatic void clear_frame();
        frame_pos  = '0;
        held       = '0;
        got_fn     = '0;
        byte_count = '0;
        verdict    = ST_OK;
        saved_exc  = '0;
    endfunction

    function automatic void expect_result(kind_t k, logic [15:0] v, status_t s,
                                          logic [7:0] e, logic l);
        parser_result_t r;
        r = '{k, v, s, e, l};
        due_results.insert(due_results.size(), r);
    endfunction

    function automatic void parse_item(logic op, logic [15:0] trans, logic [7:0] fn,
                                       logic [7:0] data, logic fe);
        logic [8:0] at;
        logic [8:0] off;
        status_t    st;
        logic [7:0] exc;
        if (op == OP_START)
        begin
            want_trans = trans;
            want_fn    = fn;
            clear_frame();
            return;
        end
        at = frame_pos;
        if (at < FRAME_LIMIT)
        begin
            frame_pos = at + 9'd1;
            if (at == 0)
                held = data;
            else if (at == 1)
            begin
                if ({held, data} != want_trans)
                    verdict = ST_TRANS;
            end
            else if (at == 7)
                got_fn = data;
            else if (at == 8)
            begin
                byte_count = data;
                if (verdict == ST_OK)
                begin
                    if (got_fn[EXC_FLAG_BIT])
                    begin
                        verdict   = ST_EXCEPT;
                        saved_exc = data;
                    end
                    else if (got_fn != want_fn)
                        verdict = ST_FUNCTION;
                end
            end
            else if (at >= HEADER_BYTES && verdict == ST_OK)
            begin
                off = 9'(at - HEADER_BYTES);
                if (got_fn == FN_READ_HOLDING || got_fn == FN_READ_INPUT)
                begin
                    // even offset holds the high byte, odd offset closes the pair
                    if (!off[0])
                        held = data;
                    else if (off < {1'b0, byte_count[7:1], 1'b0})
                        expect_result(KIND_REG, {held, data}, ST_OK, 8'h00, 1'b0);
                end
                else if (got_fn == FN_READ_COILS || got_fn == FN_READ_DISCRETE)
                begin
                    if (off < {1'b0, byte_count})
                        for (int j = 0; j < 8; j++)
                            expect_result(KIND_BIT, {15'd0, data[j]}, ST_OK, 8'h00, 1'b0);
                end
            end
        end
        if (fe)
        begin
            st  = (frame_pos < HEADER_BYTES) ? ST_SHORT : verdict;
            exc = (st == ST_EXCEPT) ? saved_exc : 8'h00;
            expect_result(KIND_STATUS, 16'h0000, st, exc, 1'b1);
            clear_frame();
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        else
            return $urandom_range(25, 60);
    endfunction

    task automatic add_start(input logic [15:0] t, input logic [7:0] f);
        response_item_t it;
        it = '{OP_START, t, f, 8'($urandom), 1'($urandom)};
        response_items.insert(response_items.size(), it);
        gen_trans = t;
        gen_fn    = f;
        frames_built++;
    endtask

    task automatic add_byte(input logic [7:0] b, input logic fe);
        response_item_t it;
        it = '{OP_BYTE, 16'($urandom), 8'($urandom), b, fe};
        response_items.insert(response_items.size(), it);
    endtask

    // Header from the given fields, random MBAP middle, random payload.
    // A nonzero cut shorter than the frame truncates it; closed marks the final byte.
    task automatic add_response(input logic [15:0] got_t, input logic [7:0] got_f,
                                input logic [7:0] b8, input int payload_n, input int cut,
                                input bit closed);
        int         total;
        logic [7:0] b;
        total = HEADER_BYTES + payload_n;
        if (cut > 0 && cut < total)
            total = cut;
        for (int i = 0; i < total; i++)
        begin
            case (i)
                0:       b = got_t[15:8];
                1:       b = got_t[7:0];
                7:       b = got_f;
                8:       b = b8;
                default: b = 8'($urandom);
            endcase
            add_byte(b, closed && i == total - 1);
        end
    endtask

    task automatic build_stimulus();
        int          sc;
        int          cnt;
        int          n;
        logic [15:0] t;
        logic [7:0]  f;
        logic [15:0] got_t;
        logic [7:0]  got_f;
        logic [7:0]  b8;
        int          cut;
        bit          closed;
        int          r;
        int          stop_at;

        gen_trans = '0;
        gen_fn    = '0;

        // byte with no start after reset: one-byte frame
        add_byte(8'h00, 1'b1);
        // register read, odd count: trailing byte dropped, next byte past the count
        add_start(16'hFFFF, FN_READ_HOLDING);
        add_response(16'hFFFF, FN_READ_HOLDING, 8'd3, 0, 0, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b1);
        // coil read, one byte closing the frame
        add_start(16'h0000, FN_READ_COILS);
        add_response(16'h0000, FN_READ_COILS, 8'd1, 0, 0, 1'b0);
        add_byte(8'hA5, 1'b1);

        stop_at = response_items.size() + RANDOM_ITEMS;
        while (response_items.size() < stop_at)
        begin
            sc = $urandom_range(0, 99);
            r  = $urandom_range(0, 99);
            t  = 16'($urandom);
            if (r < 70)
                f = 8'($urandom_range(1, 4));
            else if (r < 85)
                f = 8'($urandom_range(5, 16));
            else
                f = 8'($urandom);
            cnt = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 6) : $urandom_range(0, 255);
            n   = (cnt <= 8 && $urandom_range(0, 3) != 0) ? cnt + $urandom_range(0, 2)
                                                          : $urandom_range(0, 10);
            if (sc >= 90 && sc < 95)
            begin
                // continue with the previous expectations
                t = gen_trans;
                f = gen_fn;
            end
            else
                add_start(t, f);

            got_t  = t;
            got_f  = f;
            b8     = 8'(cnt);
            cut    = 0;
            closed = 1'b1;
            if (sc >= 95)
            begin
                // noise: random bytes, random frame ends
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                    add_byte(8'($urandom), ($urandom_range(0, 5) == 0));
                continue;
            end
            else if (sc >= 50 && sc < 60)
            begin
                got_t = t ^ (16'd1 << $urandom_range(0, 15));
                if ($urandom_range(0, 1))
                    got_f = f | 8'h80;
            end
            else if (sc >= 60 && sc < 70)
            begin
                got_f = f | 8'h80;
                b8    = 8'($urandom);
                n     = $urandom_range(0, 3);
            end
            else if (sc >= 70 && sc < 78)
                got_f = f ^ (8'd1 << $urandom_range(0, 6));
            else if (sc >= 78 && sc < 86)
                cut = $urandom_range(1, 8);
            else if (sc >= 86 && sc < 90)
            begin
                // leave the frame open; the next start drops it
                cut    = $urandom_range(1, HEADER_BYTES + n);
                closed = 1'b0;
            end
            add_response(got_t, got_f, b8, n, cut, closed);
        end

        t = 16'($urandom);
        add_start(t, FN_READ_INPUT);
        add_response(t, FN_READ_INPUT, 8'd4, 4, 0, 1'b1);
    endtask

    // Driver
    int send_gap;
    int send_calm;

    always @(posedge clk or negedge rst_n)
    begin
        int             gap;
        response_item_t nxt;
        if (!rst_n)
        begin
            in_ch.valid                <= 1'b0;
            in_ch.operation            <= OP_START;
            in_ch.expected_transaction <= '0;
            in_ch.expected_function    <= '0;
            in_ch.data_byte            <= '0;
            in_ch.frame_end            <= 1'b0;
            send_gap                   <= 0;
            send_calm                  <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                parse_item(in_ch.operation, in_ch.expected_transaction,
                           in_ch.expected_function, in_ch.data_byte, in_ch.frame_end);
                items_taken <= items_taken + 1;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap    <= send_gap - 1;
                    in_ch.valid <= 1'b0;
                end
                else if (response_items.size() > 0)
                begin
                    nxt = response_items.pop_front();
                    in_ch.valid                <= 1'b1;
                    in_ch.operation            <= nxt.op;
                    in_ch.expected_transaction <= nxt.trans;
                    in_ch.expected_function    <= nxt.fn;
                    in_ch.data_byte            <= nxt.data;
                    in_ch.frame_end            <= nxt.fe;
                    if (send_calm > 0)
                    begin
                        send_calm <= send_calm - 1;
                        gap = 0;
                    end
                    else
                    begin
                        gap = pick_gap();
                        if ($urandom_range(0, 15) == 0)
                            send_calm <= $urandom_range(15, 40);
                    end
                    send_gap <= gap;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, once, so the job queue fills and the input stalls
    logic hold_active;
    logic hold_done;
    int   hold_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_active <= 1'b0;
            hold_done   <= 1'b0;
            hold_left   <= 0;
        end
        else if (hold_active)
        begin
            if (hold_left <= 1)
                hold_active <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            hold_active <= 1'b1;
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
        end
    end

    // Monitor and checker
    int take_stall;
    int take_calm;

    always @(posedge clk or negedge rst_n)
    begin
        int             stall;
        parser_result_t want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            take_stall   <= 0;
            take_calm    <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen <= results_seen + 1;
                if (out_ch.kind == KIND_STATUS)
                    statuses_seen <= statuses_seen + 1;
                if (due_results.size() == 0)
                begin
                    $display("%0t: unexpected result kind %0d value %h status %0d exc %h last %b",
                             $time, out_ch.kind, out_ch.value, out_ch.status,
                             out_ch.exception_code, out_ch.last);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (out_ch.kind !== want.kind || out_ch.value !== want.value ||
                        out_ch.status !== want.status || out_ch.exception_code !== want.exc ||
                        out_ch.last !== want.last)
                    begin
                        $display("%0t: expected kind %0d value %h status %0d exc %h last %b",
                                 $time, want.kind, want.value, want.status, want.exc,
                                 want.last);
                        $display("%0t:   actual kind %0d value %h status %0d exc %h last %b",
                                 $time, out_ch.kind, out_ch.value, out_ch.status,
                                 out_ch.exception_code, out_ch.last);
                        mismatches = mismatches + 1;
                    end
                end
            end

            if (hold_active)
                out_ch.ready <= 1'b0;
            else if (take_stall > 0)
            begin
                out_ch.ready <= 1'b0;
                take_stall   <= take_stall - 1;
            end
            else if (out_ch.valid && out_ch.ready)
            begin
                if (take_calm > 0)
                begin
                    take_calm <= take_calm - 1;
                    stall = 0;
                end
                else
                begin
                    stall = pick_gap();
                    if ($urandom_range(0, 15) == 0)
                        take_calm <= $urandom_range(15, 40);
                end
                out_ch.ready <= (stall == 0);
                take_stall   <= (stall == 0) ? 0 : stall - 1;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Watchdog: abort when nothing moves on either side for too long
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= WATCHDOG_CYCLES)
            begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $time, WATCHDOG_CYCLES, due_results.size());
                $display("modbus_tcp_response_parser: mismatch");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n                      = 1'b0;
        in_ch.valid                = 1'b0;
        in_ch.operation            = OP_START;
        in_ch.expected_transaction = '0;
        in_ch.expected_function    = '0;
        in_ch.data_byte            = '0;
        in_ch.frame_end            = 1'b0;
        out_ch.ready               = 1'b0;
        want_trans                 = '0;
        want_fn                    = '0;
        clear_frame();
        build_stimulus();
        total_items = response_items.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (items_taken != total_items)
            @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d items over %0d started responses, with random gaps and a long stall.",
                 total_items, frames_built);
        $display("Checked %0d results, %0d of them closing status; %0d mismatches.",
                 results_seen, statuses_seen, mismatches);
        if (mismatches == 0)
            $display("modbus_tcp_response_parser: match");
        else
            $display("modbus_tcp_response_parser: mismatch");
        $finish;
    end

endmodule

[modbus_tcp_response_parser.f]
+incdir+hw/rtl
hw/rtl/mtrp_pkg.sv
hw/rtl/mtrp_if.sv
hw/rtl/mtrp_front.sv
hw/rtl/mtrp_queue.sv
hw/rtl/mtrp_back.sv
hw/rtl/modbus_tcp_response_parser.sv
test/tb.sv
